// ===== src/obd_erp_pkg.sv =====
// ----------------------------------------------------------------------------
// obd_erp_pkg
// Shared types, codes and helper functions for the adapter response parser.
// ----------------------------------------------------------------------------
package obd_erp_pkg;

    typedef enum logic [2:0] {
        KIND_SPEED   = 3'd0,
        KIND_RPM     = 3'd1,
        KIND_COOLANT = 3'd2,
        KIND_BATTERY = 3'd3,
        KIND_ERROR   = 3'd4
    } t_reading_kind;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } t_hex_digit;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_E     = 8'h45;

    localparam logic [7:0] MODE01_REPLY = 8'h41;
    localparam logic [7:0] PID_SPEED    = 8'h0D;
    localparam logic [7:0] PID_RPM      = 8'h0C;
    localparam logic [7:0] PID_COOLANT  = 8'h05;
    localparam logic [7:0] PID_BATTERY  = 8'h42;

    localparam logic [2:0] ERR_TEXT_LEN   = 3'd5;
    localparam logic [3:0] HEX_MAX_DIGITS = 4'd8;
    localparam logic [3:0] HEX_MIN_DIGITS = 4'd6;
    localparam logic [6:0] MIN_DECODE_LEN = 7'd4;
    localparam logic [6:0] MIN_LEN_RESET  = 7'd6;

    localparam logic [14:0] COOLANT_OFFSET = 15'd40;
    localparam logic [16:0] BATT_ROUND     = 17'd50;
    // floor(x/100) == (x * 83887) >> 23 for every x below 91180
    // (the battery sum never exceeds 65585)
    localparam logic [16:0] DIV100_MULT    = 17'd83887;
    localparam int          DIV100_SHIFT   = 23;

    // Character of "ERROR" at a given match position
    function automatic logic [7:0] err_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h45;
            3'd1:    c = 8'h52;
            3'd2:    c = 8'h52;
            3'd3:    c = 8'h4F;
            3'd4:    c = 8'h52;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic t_hex_digit hex_decode(input logic [7:0] c);
        t_hex_digit d;
        d.valid = 1'b1;
        d.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d.value = 4'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d.value = 4'(c - 8'h37);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d.value = 4'(c - 8'h57);
        end else begin
            d.valid = 1'b0;
        end
        return d;
    endfunction

endpackage

// ===== src/obd_elm_response_parser_core.sv =====
// Timing: a byte that ends a line is first taken into the input register, and the
//   result register then loads from its decode; an output stall can hold it between.
// Throughput: one byte per cycle unless a reading waits on a stalled full output;
//   per-byte update and line-end decode (17x17 battery divide) fit in one stage.
// Reset: synchronous, active low; clears the line state and both valid flags,
//   and sets min_line_length to 6.
// ----------------------------------------------------------------------------
// obd_elm_response_parser_core
// Byte-wide line parser for adapter text replies. Collects a line, spots
// "ERROR", gathers hex digits and decodes mode 01 speed, rpm, coolant and
// battery voltage replies into at most one reading per line.
// ----------------------------------------------------------------------------
module obd_elm_response_parser_core
    import obd_erp_pkg::*;
#(
    parameter int LINE_CAPACITY = 80
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // byte input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_rx_byte,
    // reading output channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_reading_kind,
    output logic signed [14:0] o_reading_value,
    // configuration write channel (min_line_length)
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [6:0]         i_cfg_data
);

    // line_length holds 0 .. LINE_CAPACITY-1
    localparam int LEN_W = $clog2(LINE_CAPACITY);
    localparam int CMP_W = LEN_W + 7;
    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LINE_CAPACITY - 1);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic             r_in_valid;
    logic [7:0]       r_in_byte;

    logic [6:0]       r_min_len;

    logic [LEN_W-1:0] r_line_len,     n_line_len;
    logic [3:0]       r_hex_count,    n_hex_count;
    logic [31:0]      r_hex_nibbles,  n_hex_nibbles;
    logic [2:0]       r_err_progress, n_err_progress;
    logic             r_err_seen,     n_err_seen;

    logic             r_out_valid;
    t_reading_kind    r_out_kind;
    logic [14:0]      r_out_value;

    // ------------------------------------------------------------------
    // Handshake. The decode stage moves on unless it holds a reading
    // and the result register is full and stalled.
    // ------------------------------------------------------------------
    logic          out_free;
    logic          advance;
    logic          is_eol;
    logic          res_valid;
    t_reading_kind res_kind;
    logic [14:0]   res_value;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && (!res_valid || out_free);
    assign o_in_stall = r_in_valid && !advance;
    assign o_cfg_ready = 1'b1;

    assign o_out_valid     = r_out_valid;
    assign o_reading_kind  = r_out_kind;
    assign o_reading_value = r_out_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len <= MIN_LEN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_min_len <= i_cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Line-end decode, from the state the line has built so far
    // ------------------------------------------------------------------
    logic [7:0]  hdr_byte, pid_byte, a_byte, b_byte;
    logic        len_ok;
    logic [16:0] batt_sum;
    logic [33:0] batt_prod;

    assign hdr_byte = r_hex_nibbles[31:24];
    assign pid_byte = r_hex_nibbles[23:16];
    assign a_byte   = r_hex_nibbles[15:8];
    assign b_byte   = r_hex_nibbles[7:0];

    assign is_eol = (r_in_byte == CHAR_CR) || (r_in_byte == CHAR_LF);

    assign len_ok = ({{7{1'b0}}, r_line_len} >= {{LEN_W{1'b0}}, r_min_len})
                 && ({{7{1'b0}}, r_line_len} >= {{LEN_W{1'b0}}, MIN_DECODE_LEN});

    // (256*A + B + 50) / 100 by reciprocal multiply
    assign batt_sum  = {1'b0, a_byte, b_byte} + BATT_ROUND;
    assign batt_prod = batt_sum * DIV100_MULT;

    always_comb begin
        res_valid = 1'b0;
        res_kind  = KIND_ERROR;
        res_value = 15'd0;
        if (r_in_valid && is_eol && len_ok) begin
            if (r_err_seen) begin
                res_valid = 1'b1;
            end else if (r_hex_count >= HEX_MIN_DIGITS && hdr_byte == MODE01_REPLY) begin
                case (pid_byte)
                    PID_SPEED: begin
                        res_valid = 1'b1;
                        res_kind  = KIND_SPEED;
                        res_value = {7'd0, a_byte};
                    end
                    PID_RPM: begin
                        res_valid = (r_hex_count >= HEX_MAX_DIGITS);
                        res_kind  = KIND_RPM;
                        res_value = {1'b0, a_byte, b_byte[7:2]};
                    end
                    PID_COOLANT: begin
                        res_valid = 1'b1;
                        res_kind  = KIND_COOLANT;
                        res_value = {7'd0, a_byte} - COOLANT_OFFSET;
                    end
                    PID_BATTERY: begin
                        res_valid = (r_hex_count >= HEX_MAX_DIGITS);
                        res_kind  = KIND_BATTERY;
                        res_value = {4'd0, batt_prod[33:DIV100_SHIFT]};
                    end
                    default: begin
                        res_valid = 1'b0;
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Per-byte line state update
    // ------------------------------------------------------------------
    t_hex_digit hex_d;
    logic       keep;
    logic       err_match;
    logic [2:0] err_next;
    logic [4:0] nib_lsb;

    assign hex_d     = hex_decode(r_in_byte);
    assign keep      = (r_in_byte >= CHAR_SPACE) && (r_line_len < LEN_LIMIT);
    assign err_match = (r_err_progress < ERR_TEXT_LEN)
                    && (r_in_byte == err_char(r_err_progress));
    assign err_next  = err_match ? r_err_progress + 3'd1
                     : ((r_in_byte == CHAR_E) ? 3'd1 : 3'd0);
    // first digit lands in bits 31..28
    assign nib_lsb   = {3'd7 - r_hex_count[2:0], 2'b00};

    always_comb begin
        n_line_len     = r_line_len;
        n_hex_count    = r_hex_count;
        n_hex_nibbles  = r_hex_nibbles;
        n_err_progress = r_err_progress;
        n_err_seen     = r_err_seen;
        if (is_eol) begin
            // every line end starts a fresh line
            n_line_len     = '0;
            n_hex_count    = 4'd0;
            n_hex_nibbles  = 32'd0;
            n_err_progress = 3'd0;
            n_err_seen     = 1'b0;
        end else if (keep) begin
            n_line_len = r_line_len + LEN_W'(1);
            if (!r_err_seen) begin
                if (err_next == ERR_TEXT_LEN) begin
                    n_err_seen     = 1'b1;
                    n_err_progress = 3'd0;
                end else begin
                    n_err_progress = err_next;
                end
            end
            if (hex_d.valid && r_hex_count < HEX_MAX_DIGITS) begin
                n_hex_nibbles[nib_lsb +: 4] = hex_d.value;
                n_hex_count = r_hex_count + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_len     <= '0;
            r_hex_count    <= 4'd0;
            r_hex_nibbles  <= 32'd0;
            r_err_progress <= 3'd0;
            r_err_seen     <= 1'b0;
        end else if (advance) begin
            r_line_len     <= n_line_len;
            r_hex_count    <= n_hex_count;
            r_hex_nibbles  <= n_hex_nibbles;
            r_err_progress <= n_err_progress;
            r_err_seen     <= n_err_seen;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res_valid) begin
            r_out_kind  <= res_kind;
            r_out_value <= res_value;
        end
    end

`ifndef SYNTHESIS
    // error readings always carry a zero value
    a_err_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == KIND_ERROR) |-> (r_out_value == 15'd0))
        else $error("error reading with nonzero value");

    // digit count saturates at eight
    a_hex_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hex_count <= HEX_MAX_DIGITS)
        else $error("hex digit count overflow");

    // match progress restarts once the full text is seen
    a_err_progress_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err_progress < ERR_TEXT_LEN)
        else $error("error match progress out of range");

    // a processed line end leaves an empty line
    a_eol_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && is_eol) |=> (r_line_len == '0 && r_hex_count == 4'd0 && !r_err_seen))
        else $error("line state not cleared at line end");

    // a stalled reading is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !(advance && res_valid))
        else $error("result register overwritten while stalled");
`endif

endmodule
